[rtl/asvm_pkg.sv]
package asvm_pkg;

	// input transaction: mode selects tick or one of the set-point writes
	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] value;
	} in_item_t;

	// result transaction of a publishing tick
	typedef struct packed {
		logic [15:0] speed_out;
		logic [15:0] voltage_out;
		logic [23:0] current_out;
	} out_item_t;

	// input modes
	localparam logic [1:0] MODE_TICK       = 2'd0;
	localparam logic [1:0] MODE_SET_TARGET = 2'd1;
	localparam logic [1:0] MODE_SET_ENABLE = 2'd2;
	localparam logic [1:0] MODE_SET_LOAD   = 2'd3;

	// register indexes on the configuration port
	localparam logic [2:0] REG_RAMP_STEP = 3'd0;
	localparam logic [2:0] REG_CUT_IN    = 3'd1;
	localparam logic [2:0] REG_RATED     = 3'd2;
	localparam logic [2:0] REG_REST_V    = 3'd3;
	localparam logic [2:0] REG_REG_V     = 3'd4;

	// register reset values
	localparam logic [15:0] RAMP_STEP_RST = 16'd20;
	localparam logic [15:0] CUT_IN_RST    = 16'd800;
	localparam logic [15:0] RATED_RST     = 16'd6000;
	localparam logic [15:0] REST_V_RST    = 16'd12600;
	localparam logic [15:0] REG_V_RST     = 16'd14200;

	// millivolts per milliohm to milliamps
	localparam logic [15:0] CUR_SCALE = 16'd1000;

	// serial multiply-divide unit sizes
	localparam int MD_A_W    = 16;
	localparam int MD_B_W    = 16;
	localparam int MD_D_W    = 24;
	localparam int MD_P_W    = MD_A_W + MD_B_W;
	localparam int MD_CNT_W  = $clog2(MD_P_W);

	// control sequencer of the top level
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VOLT,
		ST_VWAIT,
		ST_CUR,
		ST_CWAIT,
		ST_PUB
	} ctrl_state_t;

	// phases of the multiply-divide unit
	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_phase_t;

	// request to the multiply-divide unit: q = a*b/d
	typedef struct packed {
		logic              start;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_D_W-1:0] d;
	} md_req_t;

	// response: one-cycle done with the quotient
	typedef struct packed {
		logic              done;
		logic [MD_P_W-1:0] q;
	} md_rsp_t;

endpackage

[rtl/alternator_speed_voltage_model.sv]
// Alternator plant model for hardware-in-the-loop use, in whole rpm, mV, mOhm and mA.
// Set-point transactions (speed target, field enable, load) give no result. A tick ramps
// the shaft speed, then forms the voltage and the load current each through one pass of a
// shared bit-serial multiply-divide unit (a shift-add multiply, then a long division); the
// voltage pass is skipped when the field is off or the speed is 0, the current pass when
// the load is open. That serial unit sets the rate. A tick that changes no output gives no
// result. The finished result sits in an output register, so set-point transactions are
// taken while it waits; a further tick holds in its last step until the previous result
// has been taken.
module alternator_speed_voltage_model (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  asvm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output asvm_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// configuration registers
	logic [15:0] ramp_step_q, cut_in_q, rated_q, rest_v_q, reg_v_q;
	logic [2:0]  reg_idx;
	logic        cfg_wr;

	// plant state
	logic [15:0] speed_target_q;
	logic        field_en_q;
	logic [23:0] load_q;
	logic [15:0] shaft_q;
	logic        has_pub_q;

	// tick working registers
	asvm_pkg::ctrl_state_t state_q, state_d;
	logic [15:0] volt_q;
	logic [23:0] cur_q;
	logic        above_q, dv_neg_q;

	// published result, doubles as the last published values
	asvm_pkg::out_item_t out_q;
	logic                out_valid_q;

	asvm_pkg::md_req_t md_req;
	asvm_pkg::md_rsp_t md_rsp;

	logic        in_acc, tick_acc;
	logic [15:0] target, new_shaft, up_gap, dn_gap;
	logic        zero_v, below;
	logic [16:0] dv;
	logic [15:0] dv_mag, span;
	logic [15:0] volt_calc, fall_v;
	logic [32:0] rise_sum;
	logic        changed, pub_load;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= asvm_pkg::RAMP_STEP_RST;
			cut_in_q    <= asvm_pkg::CUT_IN_RST;
			rated_q     <= asvm_pkg::RATED_RST;
			rest_v_q    <= asvm_pkg::REST_V_RST;
			reg_v_q     <= asvm_pkg::REG_V_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				asvm_pkg::REG_RAMP_STEP: ramp_step_q <= pwdata[15:0];
				asvm_pkg::REG_CUT_IN:    cut_in_q    <= pwdata[15:0];
				asvm_pkg::REG_RATED:     rated_q     <= pwdata[15:0];
				asvm_pkg::REG_REST_V:    rest_v_q    <= pwdata[15:0];
				asvm_pkg::REG_REG_V:     reg_v_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			asvm_pkg::REG_RAMP_STEP: prdata = {16'd0, ramp_step_q};
			asvm_pkg::REG_CUT_IN:    prdata = {16'd0, cut_in_q};
			asvm_pkg::REG_RATED:     prdata = {16'd0, rated_q};
			asvm_pkg::REG_REST_V:    prdata = {16'd0, rest_v_q};
			asvm_pkg::REG_REG_V:     prdata = {16'd0, reg_v_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// input handshake
	assign in_ready = (state_q == asvm_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign tick_acc = in_acc && (in_data.mode == asvm_pkg::MODE_TICK);

	// speed ramp toward the target
	always_comb begin
		target = field_en_q ? speed_target_q : 16'd0;
		up_gap = target - shaft_q;
		dn_gap = shaft_q - target;
		if (target >= shaft_q) begin
			new_shaft = (up_gap <= ramp_step_q) ? target : shaft_q + ramp_step_q;
		end else begin
			new_shaft = (dn_gap <= ramp_step_q) ? target : shaft_q - ramp_step_q;
		end
	end

	// curve branch selection
	assign zero_v = !field_en_q || (shaft_q == 16'd0);
	assign below  = (shaft_q < cut_in_q);
	assign dv     = {1'b0, reg_v_q} - {1'b0, rest_v_q};
	assign dv_mag = dv[16] ? (rest_v_q - reg_v_q) : dv[15:0];
	assign span   = (rated_q > cut_in_q) ? (rated_q - cut_in_q) : 16'd1;

	// operands for the multiply-divide unit
	always_comb begin
		md_req.start = ((state_q == asvm_pkg::ST_VOLT) && !zero_v) ||
			((state_q == asvm_pkg::ST_CUR) && (load_q != 24'd0));
		if (state_q == asvm_pkg::ST_CUR) begin
			md_req.a = volt_q;
			md_req.b = asvm_pkg::CUR_SCALE;
			md_req.d = load_q;
		end else if (below) begin
			md_req.a = rest_v_q;
			md_req.b = shaft_q;
			md_req.d = {8'd0, cut_in_q};
		end else begin
			md_req.a = shaft_q - cut_in_q;
			md_req.b = dv_mag;
			md_req.d = {8'd0, span};
		end
	end

	asvm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// voltage from the quotient, clamped to 0 and to the regulated voltage
	always_comb begin
		rise_sum = {1'b0, md_rsp.q} + {17'd0, rest_v_q};
		fall_v   = rest_v_q - md_rsp.q[15:0];
		if (!above_q) begin
			volt_calc = md_rsp.q[15:0];
		end else if (dv_neg_q) begin
			if (md_rsp.q > {16'd0, rest_v_q}) volt_calc = 16'd0;
			else if (fall_v > reg_v_q) volt_calc = reg_v_q;
			else volt_calc = fall_v;
		end else begin
			volt_calc = (rise_sum > {17'd0, reg_v_q}) ? reg_v_q : rise_sum[15:0];
		end
	end

	// publish test against the last published values
	assign changed = !has_pub_q || (shaft_q != out_q.speed_out) ||
		(volt_q != out_q.voltage_out) || (cur_q != out_q.current_out);
	assign pub_load = (state_q == asvm_pkg::ST_PUB) && changed &&
		(!out_valid_q || out_ready);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			asvm_pkg::ST_IDLE: begin
				if (tick_acc) state_d = asvm_pkg::ST_VOLT;
			end
			asvm_pkg::ST_VOLT: begin
				state_d = zero_v ? asvm_pkg::ST_CUR : asvm_pkg::ST_VWAIT;
			end
			asvm_pkg::ST_VWAIT: begin
				if (md_rsp.done) state_d = asvm_pkg::ST_CUR;
			end
			asvm_pkg::ST_CUR: begin
				state_d = (load_q == 24'd0) ? asvm_pkg::ST_PUB : asvm_pkg::ST_CWAIT;
			end
			asvm_pkg::ST_CWAIT: begin
				if (md_rsp.done) state_d = asvm_pkg::ST_PUB;
			end
			asvm_pkg::ST_PUB: begin
				if (!changed || pub_load) state_d = asvm_pkg::ST_IDLE;
			end
			default: state_d = asvm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= asvm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// plant state and set points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_target_q <= 16'd0;
			field_en_q     <= 1'b1;
			load_q         <= 24'd0;
			shaft_q        <= 16'd0;
		end else if (in_acc) begin
			case (in_data.mode)
				asvm_pkg::MODE_TICK:       shaft_q <= new_shaft;
				asvm_pkg::MODE_SET_TARGET: begin
					speed_target_q <= (in_data.value[23:16] != 8'd0) ?
						16'hFFFF : in_data.value[15:0];
				end
				asvm_pkg::MODE_SET_ENABLE: field_en_q <= (in_data.value != 24'd0);
				asvm_pkg::MODE_SET_LOAD:   load_q <= in_data.value;
				default: ;
			endcase
		end
	end

	// tick working registers
	always_ff @(posedge clk) begin
		case (state_q)
			asvm_pkg::ST_VOLT: begin
				above_q  <= !below;
				dv_neg_q <= dv[16];
				if (zero_v) volt_q <= 16'd0;
			end
			asvm_pkg::ST_VWAIT: begin
				if (md_rsp.done) volt_q <= volt_calc;
			end
			asvm_pkg::ST_CUR: begin
				if (load_q == 24'd0) cur_q <= 24'd0;
			end
			asvm_pkg::ST_CWAIT: begin
				if (md_rsp.done) begin
					cur_q <= (md_rsp.q[31:24] != 8'd0) ? 24'hFFFFFF : md_rsp.q[23:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q       <= '0;
			out_valid_q <= 1'b0;
			has_pub_q   <= 1'b0;
		end else if (pub_load) begin
			out_q.speed_out   <= shaft_q;
			out_q.voltage_out <= volt_q;
			out_q.current_out <= cur_q;
			out_valid_q       <= 1'b1;
			has_pub_q         <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// the serial unit only finishes while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == asvm_pkg::ST_VWAIT || state_q == asvm_pkg::ST_CWAIT))
		else $error("multiply-divide done outside a wait state");

	// a new result always leaves the published mark set
	a_pub_mark: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> has_pub_q)
		else $error("result shown without publish mark");

	// published voltage stays within the curve limits
	a_volt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.voltage_out <= reg_v_q || out_q.voltage_out < rest_v_q))
		else $error("published voltage above curve limits");

	// the sequencer never leaves the current wait state without the unit finishing
	a_wait_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == asvm_pkg::ST_CWAIT && !md_rsp.done) |=> (state_q == asvm_pkg::ST_CWAIT))
		else $error("current wait left early");
`endif

endmodule

[rtl/asvm_muldiv.sv]
// bit-serial unsigned a*b/d: shift-add multiply, then restoring long division
module asvm_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  asvm_pkg::md_req_t req,
	output asvm_pkg::md_rsp_t rsp
);

	localparam int PW = asvm_pkg::MD_P_W;
	localparam int DW = asvm_pkg::MD_D_W;
	localparam int BW = asvm_pkg::MD_B_W;
	localparam int CW = asvm_pkg::MD_CNT_W;
	localparam logic [CW-1:0] MUL_LAST = CW'(BW - 1);
	localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

	asvm_pkg::md_phase_t phase_q, phase_d;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] mcand_q;
	logic [BW-1:0] mplier_q;
	logic [PW-1:0] acc_q;
	logic [DW-1:0] dsor_q;
	logic [DW-1:0] rem_q;
	logic          done_q;

	logic [DW:0]   rem_n;
	logic          rem_ge;

	// one division step: bring down the next dividend bit and try subtracting
	assign rem_n  = {rem_q, acc_q[PW-1]};
	assign rem_ge = (rem_n >= {1'b0, dsor_q});

	// phase sequencing
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			asvm_pkg::MD_IDLE: begin
				if (req.start) phase_d = asvm_pkg::MD_MUL;
			end
			asvm_pkg::MD_MUL: begin
				if (cnt_q == MUL_LAST) phase_d = asvm_pkg::MD_DIV;
			end
			asvm_pkg::MD_DIV: begin
				if (cnt_q == DIV_LAST) phase_d = asvm_pkg::MD_IDLE;
			end
			default: phase_d = asvm_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= asvm_pkg::MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == asvm_pkg::MD_DIV) && (cnt_q == DIV_LAST);
			if (phase_q != phase_d) cnt_q <= '0;
			else if (phase_q != asvm_pkg::MD_IDLE) cnt_q <= cnt_q + 1'b1;
		end
	end

	// operand and accumulator shift registers
	always_ff @(posedge clk) begin
		case (phase_q)
			asvm_pkg::MD_IDLE: begin
				if (req.start) begin
					mcand_q  <= {{(PW - asvm_pkg::MD_A_W){1'b0}}, req.a};
					mplier_q <= req.b;
					dsor_q   <= req.d;
					acc_q    <= '0;
					rem_q    <= '0;
				end
			end
			asvm_pkg::MD_MUL: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[PW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[BW-1:1]};
			end
			asvm_pkg::MD_DIV: begin
				// the remainder stays below the divisor, so it fits the divisor width
				rem_q <= rem_ge ? DW'(rem_n - {1'b0, dsor_q}) : rem_n[DW-1:0];
				acc_q <= {acc_q[PW-2:0], rem_ge};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.q    = acc_q;

endmodule
